[design/csc_pkg.sv]
`default_nettype none
package csc_pkg;

  localparam int CUBE_W    = 32;
  localparam int FIELD_POS = 16;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    CODE_ZERO = 2'd0,
    CODE_ONE  = 2'd1,
    CODE_DC   = 2'd2,
    CODE_BAD  = 2'd3
  } code_t;

  typedef enum logic [1:0] {
    ST_CUBE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_CONTAIN = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    V_NOT_CONTAINED = 2'd0,
    V_STRICT        = 2'd1,
    V_EQUAL         = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

[design/csc_if.sv]
`default_nettype none
interface csc_in_if;
  import csc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [CUBE_W-1:0] cube_a;
  logic [CUBE_W-1:0] cube_b;
  modport source (output valid, op, cube_a, cube_b, input ready);
  modport sink   (input valid, op, cube_a, cube_b, output ready);
endinterface

interface csc_out_if;
  import csc_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [CUBE_W-1:0] result_cube;
  verdict_t          verdict;
  logic              last;
  modport source (output valid, status, result_cube, verdict, last, input ready);
  modport sink   (input valid, status, result_cube, verdict, last, output ready);
endinterface
`default_nettype wire

[design/cube_sharp_contain_unit.sv]
// An accepted word is scanned one position per cycle over the w used positions, then
// decided; the first result is registered from the decide state, or from the emit state for a split.
// A new word is taken only in idle, once the last result of the previous word is in the output
// register; the serial position scan sets the throughput.
// A sharp emits at most one result word per cycle; the output register frees the input side.
// Reset (synchronous, rst_n low) returns to idle, drops the output word and sets width to 16.
`default_nettype none
module cube_sharp_contain_unit #(
  parameter int MAX_POSITIONS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [csc_pkg::CFG_W-1:0]  cfg_wdata,
  csc_in_if.sink                     in_ch,
  csc_out_if.source                  out_ch
);
  import csc_pkg::*;

  localparam int LIM = (MAX_POSITIONS < FIELD_POS) ? MAX_POSITIONS : FIELD_POS;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  width_r, width_nxt;
  logic              op_r, op_nxt;
  logic              bad_r, bad_nxt;
  logic              conf_r, conf_nxt;
  logic [CUBE_W-1:0] a_r, a_nxt;
  logic [CUBE_W-1:0] b_r, b_nxt;
  logic [CUBE_W-1:0] a_sh_r, a_sh_nxt;
  logic [CUBE_W-1:0] b_sh_r, b_sh_nxt;
  logic [LIM-1:0]    pend_r, pend_nxt;
  logic [LIM-1:0]    pos_r, pos_nxt;
  logic [CFG_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [CUBE_W-1:0] cube_r, cube_nxt;
  verdict_t          verdict_r, verdict_nxt;
  logic              last_r, last_nxt;

  logic [CFG_W-1:0]  w_eff;
  logic [CUBE_W-1:0] wmask;
  logic [CUBE_W-1:0] posmask;
  logic [CUBE_W-1:0] emit_cube;
  logic [1:0]        comp;
  logic [LIM-1:0]    pend_rest;
  logic              out_free;
  code_t             ca, cb;

  // Width zero acts as one, oversize clamps to the position limit.
  always_comb begin
    if (width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (width_r > CFG_W'(LIM)) begin
      w_eff = CFG_W'(LIM);
    end else begin
      w_eff = width_r;
    end
  end

  always_comb begin
    wmask   = '0;
    posmask = '0;
    for (int j = 0; j < LIM; j++) begin
      wmask[2*j +: 2]   = (CFG_W'(j) < w_eff) ? 2'b11 : 2'b00;
      posmask[2*j +: 2] = {2{pos_r[j]}};
    end
  end

  assign comp      = b_sh_r[1:0] ^ 2'b01;
  assign emit_cube = (a_r & ~posmask) | ({FIELD_POS{comp}} & posmask);
  assign pend_rest = pend_r >> 1;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign ca        = code_t'(a_sh_r[1:0]);
  assign cb        = code_t'(b_sh_r[1:0]);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.result_cube = cube_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.last        = last_r;

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = cfg_we ? cfg_wdata : width_r;
    op_nxt        = op_r;
    bad_nxt       = bad_r;
    conf_nxt      = conf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    a_sh_nxt      = a_sh_r;
    b_sh_nxt      = b_sh_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    cube_nxt      = cube_r;
    verdict_nxt   = verdict_r;
    last_nxt      = last_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          a_nxt     = in_ch.cube_a & wmask;
          b_nxt     = in_ch.cube_b & wmask;
          a_sh_nxt  = in_ch.cube_a & wmask;
          b_sh_nxt  = in_ch.cube_b & wmask;
          bad_nxt   = 1'b0;
          conf_nxt  = 1'b0;
          pend_nxt  = '0;
          pos_nxt   = LIM'(1);
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ca == CODE_BAD || cb == CODE_BAD) begin
          bad_nxt = 1'b1;
        end else if (ca == CODE_DC) begin
          if (cb != CODE_DC) begin
            pend_nxt = pend_r | pos_r;
          end
        end else if (cb == CODE_DC) begin
          if (op_r) begin
            conf_nxt = 1'b1;
          end
        end else if (ca != cb) begin
          conf_nxt = 1'b1;
        end
        a_sh_nxt = a_sh_r >> 2;
        b_sh_nxt = b_sh_r >> 2;
        pos_nxt  = pos_r << 1;
        cnt_nxt  = cnt_r + CFG_W'(1);
        if (cnt_r == w_eff - CFG_W'(1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        b_sh_nxt = b_r;
        pos_nxt  = LIM'(1);
        if (!bad_r && !op_r && !conf_r && pend_r != '0) begin
          state_nxt = S_EMIT;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          cube_nxt      = '0;
          verdict_nxt   = V_NOT_CONTAINED;
          if (bad_r) begin
            status_nxt = ST_INVALID;
          end else if (op_r) begin
            status_nxt = ST_CONTAIN;
            if (conf_r) begin
              verdict_nxt = V_NOT_CONTAINED;
            end else if (pend_r != '0) begin
              verdict_nxt = V_STRICT;
            end else begin
              verdict_nxt = V_EQUAL;
            end
          end else if (conf_r) begin
            status_nxt = ST_CUBE;
            cube_nxt   = a_r;
          end else begin
            status_nxt = ST_EMPTY;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold on a pending position until the output register frees
        if (!pend_r[0] || out_free) begin
          if (pend_r[0]) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_CUBE;
            cube_nxt      = emit_cube;
            verdict_nxt   = V_NOT_CONTAINED;
            last_nxt      = (pend_rest == '0);
          end
          pend_nxt = pend_rest;
          b_sh_nxt = b_sh_r >> 2;
          pos_nxt  = pos_r << 1;
          if (pend_rest == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WIDTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    bad_r     <= bad_nxt;
    conf_r    <= conf_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    a_sh_r    <= a_sh_nxt;
    b_sh_r    <= b_sh_nxt;
    pend_r    <= pend_nxt;
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    status_r  <= status_nxt;
    cube_r    <= cube_nxt;
    verdict_r <= verdict_nxt;
    last_r    <= last_nxt;
  end

  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> pend_r != '0)
    else $error("emit phase entered with nothing pending");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r < w_eff)
    else $error("scan ran past the used positions");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_SCAN)
    else $error("accepted word did not start a scan");

  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == ST_INVALID |-> cube_r == '0 && last_r)
    else $error("invalid status word carries a cube or is not last");

  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_CONTAIN |-> verdict_r == V_NOT_CONTAINED)
    else $error("verdict set on a non-containment word");

endmodule
`default_nettype wire

[sim/cube_sharp_test_pkg.sv]
`timescale 1ns / 100ps
package cube_sharp_test_pkg;

  localparam logic OP_SHARP   = 1'b0;
  localparam logic OP_CONTAIN = 1'b1;

endpackage

[sim/cube_sharp_contain_checker.sv]
`timescale 1ns / 100ps
module cube_sharp_contain_checker
  import csc_pkg::*;
  import cube_sharp_test_pkg::*;
#(
  parameter int MAX_POSITIONS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  csc_in_if                in_mon,
  csc_out_if               out_mon,
  output int               fail_count,
  output int               words_owed
);

  typedef struct packed {
    status_t           status;
    logic [CUBE_W-1:0] cube;
    verdict_t          verdict;
    logic              last;
  } result_word_t;

  result_word_t     owed_words[$];
  logic [CFG_W-1:0] width_reg = WIDTH_RESET;
  int               fails = 0;
  int               shown = 0;
  int               owed = 0;

  assign fail_count = fails;
  assign words_owed = owed;

  function automatic int used_positions(logic [CFG_W-1:0] wr);
    int lim;
    int w;
    lim = (MAX_POSITIONS < FIELD_POS) ? MAX_POSITIONS : FIELD_POS;
    if (lim < 1) lim = 1;
    w = (wr == '0) ? 1 : int'(wr);
    if (w > lim) w = lim;
    return w;
  endfunction

  // Queue every word that one accepted input must produce, in emission order.
  task automatic predict_cube_op(logic op, logic [CUBE_W-1:0] a_in, logic [CUBE_W-1:0] b_in);
    int                  w;
    int                  p;
    int                  left;
    logic [63:0]         mask64;
    logic [CUBE_W-1:0]   a;
    logic [CUBE_W-1:0]   b;
    logic [FIELD_POS-1:0] split;
    logic                conflict;
    logic                bad;
    code_t               ca;
    code_t               cb;
    result_word_t        r;
    w = used_positions(width_reg);
    mask64 = (64'd1 << (2 * w)) - 64'd1;
    a = a_in & mask64[CUBE_W-1:0];
    b = b_in & mask64[CUBE_W-1:0];
    split = '0;
    conflict = 1'b0;
    bad = 1'b0;
    for (p = 0; p < w; p++) begin
      ca = code_t'(a[2*p +: 2]);
      cb = code_t'(b[2*p +: 2]);
      if (ca == CODE_BAD || cb == CODE_BAD) begin
        bad = 1'b1;
      end else if (ca == CODE_DC) begin
        if (cb != CODE_DC) split[p] = 1'b1;
      end else if (cb == CODE_DC) begin
        // fixed a against a free b is not containment
        if (op == OP_CONTAIN) conflict = 1'b1;
      end else if (ca != cb) begin
        conflict = 1'b1;
      end
    end
    r = '{status: ST_INVALID, cube: '0, verdict: V_NOT_CONTAINED, last: 1'b1};
    if (bad) begin
      owed_words.push_back(r);
    end else if (op == OP_CONTAIN) begin
      r.status = ST_CONTAIN;
      r.verdict = conflict ? V_NOT_CONTAINED : ((split != '0) ? V_STRICT : V_EQUAL);
      owed_words.push_back(r);
    end else if (conflict) begin
      r.status = ST_CUBE;
      r.cube = a;
      owed_words.push_back(r);
    end else if (split == '0) begin
      r.status = ST_EMPTY;
      owed_words.push_back(r);
    end else begin
      left = $countones(split);
      r.status = ST_CUBE;
      for (p = 0; p < w; p++) begin
        if (split[p]) begin
          r.cube = a;
          r.cube[2*p +: 2] = b[2*p +: 2] ^ 2'b01;
          left--;
          r.last = (left == 0);
          owed_words.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      owed_words.delete();
    end else begin
      if (cfg_we) width_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        predict_cube_op(in_mon.op, in_mon.cube_a, in_mon.cube_b);
      if (out_mon.valid && out_mon.ready) begin
        if (owed_words.size() == 0) begin
          fails++;
          if (shown < 10)
            $display("%0t: unexpected word: status %0d cube %h verdict %0d last %b", $time,
                     out_mon.status, out_mon.result_cube, out_mon.verdict, out_mon.last);
          shown++;
        end else begin
          want = owed_words.pop_front();
          if (out_mon.status !== want.status || out_mon.result_cube !== want.cube ||
              out_mon.verdict !== want.verdict || out_mon.last !== want.last) begin
            fails++;
            if (shown < 10) begin
              $write("%0t: mismatch: expected status %0d cube %h verdict %0d last %b,",
                     $time, want.status, want.cube, want.verdict, want.last);
              $display(" got status %0d cube %h verdict %0d last %b",
                       out_mon.status, out_mon.result_cube, out_mon.verdict, out_mon.last);
            end
            shown++;
          end
        end
      end
    end
    owed = owed_words.size();
  end

endmodule

[sim/cube_sharp_contain_unit_test.sv]
`timescale 1ns / 100ps
module cube_sharp_contain_unit_test;
  import csc_pkg::*;
  import cube_sharp_test_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               words_owed;
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;
  int               stall_left = 0;

  csc_in_if  in_ch ();
  csc_out_if out_ch ();

  cube_sharp_contain_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cube_sharp_contain_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_width(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > FIELD_POS) return FIELD_POS;
    return int'(v);
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!out_calm) stall_left = pick_gap();
    end
  end

  // Enter and leave at a falling edge; valid stays high after the accept.
  task automatic send_word(logic op, logic [CUBE_W-1:0] a, logic [CUBE_W-1:0] b);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.cube_a <= a;
    in_ch.cube_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_width(logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Used positions get shaped codes; positions above the width keep random noise.
  task automatic make_pair(int w, output logic [CUBE_W-1:0] a, output logic [CUBE_W-1:0] b);
    int         mode;
    int         p;
    int         pos;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] tmp;
    a = $urandom;
    b = $urandom;
    mode = $urandom_range(0, 99);
    for (p = 0; p < w; p++) begin
      ca = 2'($urandom_range(0, 2));
      if (mode < 20) begin
        cb = 2'($urandom_range(0, 2));
      end else if (mode < 60) begin
        // no fixed conflict: spread many don't-care splits
        if ($urandom_range(0, 1)) ca = CODE_DC;
        if (ca == CODE_DC) cb = 2'($urandom_range(0, 2));
        else cb = $urandom_range(0, 1) ? ca : CODE_DC;
      end else if (mode < 80) begin
        // a inside b, swapped half the time
        if (ca == CODE_DC) cb = CODE_DC;
        else cb = ($urandom_range(0, 2) == 0) ? CODE_DC : ca;
        if (mode < 70) begin
          tmp = ca;
          ca = cb;
          cb = tmp;
        end
      end else begin
        cb = ca;
      end
      a[2*p +: 2] = ca;
      b[2*p +: 2] = cb;
    end
    if (mode >= 92) begin
      pos = $urandom_range(0, w - 1);
      if ($urandom_range(0, 1)) a[2*pos +: 2] = CODE_BAD;
      else b[2*pos +: 2] = CODE_BAD;
    end
  endtask

  initial begin
    logic [CFG_W-1:0]  widths[9];
    logic [CUBE_W-1:0] a;
    logic [CUBE_W-1:0] b;
    int                k;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_SHARP;
    in_ch.cube_a = '0;
    in_ch.cube_b = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full width after reset
    send_word(OP_SHARP,   32'h0000_0000, 32'h0000_0000);
    send_word(OP_CONTAIN, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_SHARP,   32'hAAAA_AAAA, 32'h0000_0000);
    send_word(OP_SHARP,   32'hAAAA_AAAA, 32'h5555_5555);
    send_word(OP_CONTAIN, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(OP_CONTAIN, 32'h0000_0000, 32'hAAAA_AAAA);
    send_word(OP_SHARP,   32'h5555_5555, 32'hAAAA_AAAA);
    send_word(OP_SHARP,   32'h5555_5555, 32'h5555_5555);
    send_word(OP_SHARP,   32'hA555_555A, 32'h5555_5554);
    send_word(OP_CONTAIN, 32'h5555_5555, 32'h0000_0000);
    send_word(OP_SHARP,   32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_CONTAIN, 32'h0000_0000, 32'hC000_0000);
    send_word(OP_SHARP,   32'h8000_0000, 32'h4000_0000);
    send_word(OP_CONTAIN, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    // one position: upper bits must be ignored
    write_width(5'd1);
    send_word(OP_SHARP,   32'hFFFF_FFFE, 32'hFFFF_FFFD);
    send_word(OP_CONTAIN, 32'hFFFF_FFFE, 32'hFFFF_FFFD);
    send_word(OP_SHARP,   32'h0000_0003, 32'h0000_0000);
    write_width(5'd0);
    send_word(OP_SHARP,   32'hFFFF_FFF2, 32'hFFFF_FFF0);
    write_width(5'd31);
    send_word(OP_SHARP,   32'hAAAA_AAAA, 32'hFFFF_FFFF);
    send_word(OP_SHARP,   32'hAAAA_AAAA, 32'h1555_5555);

    widths = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd9, 5'd0, 5'd0};
    widths[7] = 5'($urandom_range(0, 31));
    widths[8] = 5'($urandom_range(2, 15));
    foreach (widths[i]) begin
      write_width(widths[i]);
      for (k = 0; k < 50; k++) begin
        if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
        make_pair(eff_width(widths[i]), a, b);
        send_word($urandom_range(0, 2) == 0 ? OP_CONTAIN : OP_SHARP, a, b);
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
